### hw/rtl/ispc_pkg.sv
package ispc_pkg;

  // Subnet table geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PFX_W  = 6;
  localparam int unsigned EIDX_W = 6;

  // Stream word layout
  localparam int unsigned S_TDATA_W = 112;
  localparam int unsigned M_TDATA_W = 8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_SCAN2,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic write;     // store table entry from the input word
    logic capture;   // latch query addresses, start first pass
    logic restart;   // start second pass on the second address
    logic scan;      // advance the table read
    logic take1;     // first pass hit: allocated, same from compare
    logic take2;     // second pass done: allocated from hit
    logic out_load;  // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic stop;
    logic exhausted;
    logic out_free;
  } stat_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] p);
    logic [ADDR_W-1:0] m;
    if (p == '0) begin
      m = '0;
    end else if (p >= PFX_W'(ADDR_W)) begin
      m = '1;
    end else begin
      m = {ADDR_W{1'b1}} << (PFX_W'(ADDR_W) - p);
    end
    return m;
  endfunction

endpackage

### hw/rtl/ipv4_subnet_pair_classifier.sv
// Channel  Dir  Signals                       Payload (low bit up)
// cfg      in   cfg_wen, cfg_wdata[6:0]       entry_count
// s_axis   in   tvalid, tready, tdata, tuser  tdata: entry_index, entry_base, entry_prefix,
//                                             first_address, second_address; tuser: mode
// m_axis   out  tvalid, tready, tdata         same_subnet, allocated
//
// A table write word gives no output word.
// A query scans the table one entry per cycle through its single read port:
// each pass reads up to N entries (N = min(entry_count, 64)), at most two
// passes, then the result is moved out and the controller goes back to idle.
// rst is synchronous: entry_count clears, table contents stay undefined.
// The output register holds its word while m_axis_tready is low; a new
// write word is still taken, a query waits before its result is loaded.
module ipv4_subnet_pair_classifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [6:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[5:0], entry_base[37:6], entry_prefix[43:38],
  // first_address[75:44], second_address[107:76], zero pad[111:108]
  input  logic [ispc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // mode[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // same_subnet[0], allocated[1], zero pad[7:2]
  output logic [ispc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import ispc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  s_ready;
  logic  m_same;
  logic  m_alloc;

  assign s_axis_tready = s_ready;
  assign m_axis_tdata  = {6'b0, m_alloc, m_same};

  ispc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_mode  (s_axis_tuser[0]),
    .s_ready (s_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Unpack the input word and run the table, compare and output register
  ispc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .entry_index    (s_axis_tdata[5:0]),
    .entry_base     (s_axis_tdata[37:6]),
    .entry_prefix   (s_axis_tdata[43:38]),
    .first_address  (s_axis_tdata[75:44]),
    .second_address (s_axis_tdata[107:76]),
    .cmd            (cmd),
    .stat           (stat),
    .m_valid        (m_axis_tvalid),
    .m_ready        (m_axis_tready),
    .m_same         (m_same),
    .m_alloc        (m_alloc)
  );

endmodule

### hw/rtl/ispc_ctrl.sv
module ispc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  input  logic           s_mode,
  output logic           s_ready,
  input  ispc_pkg::stat_t stat,
  output ispc_pkg::cmd_t  cmd
);
  import ispc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          if (s_mode == MODE_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_SCAN1;
          end
        end
      end
      ST_SCAN1: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.take1  = 1'b1;
          state_next = ST_RESULT;
        end else if (stat.stop || stat.exhausted) begin
          cmd.restart = 1'b1;
          state_next  = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.stop || stat.exhausted) begin
          cmd.take2  = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Second pass only ever follows the first
  a_scan2_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN2) |-> ($past(state) == ST_SCAN1 || $past(state) == ST_SCAN2))
    else $error("second pass entered without a first pass");

  // A result is produced only after a scan
  a_result_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_RESULT) |-> ($past(state) == ST_SCAN1 || $past(state) == ST_SCAN2))
    else $error("result state entered without a scan");

  // Hold the finished result while the output register is still occupied
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && !stat.out_free) |=> (state == ST_RESULT))
    else $error("result state left while the output register was busy");

endmodule

### hw/rtl/ispc_dp.sv
module ispc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [ispc_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic [ispc_pkg::EIDX_W-1:0]         entry_index,
  input  logic [ispc_pkg::ADDR_W-1:0]         entry_base,
  input  logic [ispc_pkg::PFX_W-1:0]          entry_prefix,
  input  logic [ispc_pkg::ADDR_W-1:0]         first_address,
  input  logic [ispc_pkg::ADDR_W-1:0]         second_address,
  input  ispc_pkg::cmd_t                      cmd,
  output ispc_pkg::stat_t                     stat,
  output logic                                m_valid,
  input  logic                                m_ready,
  output logic                                m_same,
  output logic                                m_alloc
);
  import ispc_pkg::*;

  logic [ADDR_W-1:0] base_mem [DEPTH];
  logic [PFX_W-1:0]  pfx_mem  [DEPTH];

  logic [CNT_W-1:0]  entry_count;
  logic [ADDR_W-1:0] addr1;
  logic [ADDR_W-1:0] addr2;
  logic              sel2;
  logic [CNT_W-1:0]  rd_idx;
  logic              pend;
  logic [ADDR_W-1:0] base_q;
  logic [PFX_W-1:0]  pfx_q;
  logic              res_same;
  logic              res_alloc;

  logic [CNT_W-1:0]  limit;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] mask;
  logic              rd_go;
  logic              same_ok;

  assign limit    = (entry_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : entry_count;
  assign cur_addr = sel2 ? addr2 : addr1;
  assign mask     = prefix_mask(pfx_q);
  assign rd_go    = cmd.scan && (rd_idx < limit);
  assign same_ok  = (base_q == (addr2 & mask));

  assign stat.hit       = pend && (base_q == (cur_addr & mask));
  assign stat.stop      = pend && (base_q > cur_addr);
  assign stat.exhausted = !pend && (rd_idx >= limit);
  assign stat.out_free  = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      base_mem[entry_index[IDX_W-1:0]] <= entry_base;
      pfx_mem[entry_index[IDX_W-1:0]]  <= entry_prefix;
    end
    if (rd_go) begin
      base_q <= base_mem[rd_idx[IDX_W-1:0]];
      pfx_q  <= pfx_mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wen) begin
      entry_count <= cfg_wdata;
    end
  end

  // Scan pointer and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      sel2   <= 1'b0;
    end else if (cmd.capture) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      sel2   <= 1'b0;
    end else if (cmd.restart) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      sel2   <= 1'b1;
    end else if (cmd.scan) begin
      pend <= rd_go;
      if (rd_go) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr1 <= first_address;
      addr2 <= second_address;
    end
    if (cmd.take1) begin
      res_same  <= same_ok;
      res_alloc <= 1'b1;
    end else if (cmd.take2) begin
      res_same  <= 1'b0;
      res_alloc <= stat.hit;
    end
    if (cmd.out_load) begin
      m_same  <= res_same;
      m_alloc <= res_alloc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  a_hit_stop_excl: assert property (@(posedge clk) disable iff (rst)
    !(stat.hit && stat.stop))
    else $error("entry both matches and ends the scan");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= CNT_W'(DEPTH))
    else $error("scan pointer beyond table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_valid || m_ready))
    else $error("result loaded over an untaken word");

  a_pend_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pend) |-> $past(rd_go))
    else $error("compare stage without a table read");

endmodule
